// ----- rtl/kerc_pkg.sv -----
// ----------------------------------------------------------------------------
// kerc_pkg: shared types and constants of the key exchange request checker
// Holds the record type codes, error codes, parser phases, the queue entry
// type that links the front and back parts, and default parameter values.
// ----------------------------------------------------------------------------
`default_nettype none

package kerc_pkg;

  // Default limits, handed to the top level parameters.
  localparam int unsigned MaxMessageBytes = 16384;
  localparam int unsigned BodyScanBytes   = 256;

  // Depth of the queue between the front and the back part (power of two).
  localparam int unsigned QueueDepth = 4;

  // Reset values of the configuration registers.
  localparam logic [15:0] WantedProtocolReset = 16'd0;
  localparam logic [15:0] WantedAeadReset     = 16'd15;

  // Configuration register indexes.
  localparam logic CfgIdxProtocol = 1'b0;
  localparam logic CfgIdxAead     = 1'b1;

  // Record types.
  localparam logic [14:0] RecEom       = 15'd0;
  localparam logic [14:0] RecNextProto = 15'd1;
  localparam logic [14:0] RecError     = 15'd2;
  localparam logic [14:0] RecWarning   = 15'd3;
  localparam logic [14:0] RecAead      = 15'd4;
  localparam logic [14:0] RecCookie    = 15'd5;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrCritical = 2'd1,
    ErrBad      = 2'd2
  } err_e;

  // Parser position: four header bytes, then the body.
  typedef enum logic [2:0] {
    PhHdr0 = 3'd0,
    PhHdr1 = 3'd1,
    PhHdr2 = 3'd2,
    PhHdr3 = 3'd3,
    PhBody = 3'd4
  } phase_e;

  // One classified item on its way from the front to the back part.
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
    logic       over_limit;  // byte lies beyond the message size limit
  } q_entry_t;

endpackage

`default_nettype wire

// ----- rtl/kerc_front.sv -----
// ----------------------------------------------------------------------------
// kerc_front: input side of the key exchange request checker
// Accepts bytes, counts them per message and tags each byte that lies beyond
// the message size limit before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kerc_front #(
  parameter int unsigned MAX_MESSAGE_BYTES = kerc_pkg::MaxMessageBytes
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         msg_byte_i,
  input  wire logic               last_byte_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output kerc_pkg::q_entry_t      q_entry_o
);

  localparam int unsigned CntW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [CntW-1:0] CntLimit = CntW'(MAX_MESSAGE_BYTES);

  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic            at_limit;

  assign at_limit   = (byte_count_q >= CntLimit);
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign q_entry_o.msg_byte   = msg_byte_i;
  assign q_entry_o.last_byte  = last_byte_i;
  assign q_entry_o.over_limit = at_limit;

  // The count saturates at the limit and restarts with every new message.
  always_comb begin
    byte_count_d = byte_count_q;
    if (q_push_o) begin
      if (last_byte_i) begin
        byte_count_d = '0;
      end else if (!at_limit) begin
        byte_count_d = byte_count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else begin
      byte_count_q <= byte_count_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kerc_queue.sv -----
// ----------------------------------------------------------------------------
// kerc_queue: short queue between the front and back parts
// A small first-in first-out store of classified bytes, so that either side
// can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module kerc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire kerc_pkg::q_entry_t push_entry_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output kerc_pkg::q_entry_t      head_o
);

  localparam int unsigned PtrW = $clog2(kerc_pkg::QueueDepth);

  kerc_pkg::q_entry_t mem_q [kerc_pkg::QueueDepth];
  logic [PtrW:0]      wr_ptr_q, rd_ptr_q;

  // Pointers carry one extra bit to tell full from empty.
  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[PtrW] != rd_ptr_q[PtrW]) &&
                   (wr_ptr_q[PtrW-1:0] == rd_ptr_q[PtrW-1:0]);
  assign head_o  = mem_q[rd_ptr_q[PtrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[PtrW-1:0]] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + (PtrW+1)'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + (PtrW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kerc_back.sv -----
// ----------------------------------------------------------------------------
// kerc_back: record parser and result register
// Takes one queued byte per cycle (a final byte waits for a free result
// register), walks the record framing, applies the request rules, searches
// bodies for wanted ids and registers one result at each message's final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module kerc_back #(
  parameter int unsigned BODY_SCAN_BYTES = kerc_pkg::BodyScanBytes
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               q_empty_i,
  input  wire kerc_pkg::q_entry_t q_head_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_data_o
);

  localparam int unsigned OffW = $clog2(BODY_SCAN_BYTES + 1);
  localparam logic [OffW-1:0] ScanLimit = OffW'(BODY_SCAN_BYTES);

  logic [15:0] wanted_proto_q, wanted_aead_q;

  kerc_pkg::phase_e phase_q, phase_d;
  logic [14:0]      rec_type_q, rec_type_d;
  logic             rec_crit_q, rec_crit_d;
  logic [15:0]      body_left_q, body_left_d;
  logic [OffW-1:0]  body_off_q, body_off_d;
  logic [7:0]       word_high_q, word_high_d;
  kerc_pkg::err_e   err_q, err_d;
  logic             saw_proto_q, saw_proto_d;
  logic             proto_found_q, proto_found_d;
  logic             aead_found_q, aead_found_d;
  logic             last_eom_q, last_eom_d;
  logic             len_over_q, len_over_d;

  logic             out_valid_q, out_valid_d;
  logic [4:0]       out_bits_q, out_bits_d;

  logic             can_finish;
  logic [7:0]       b;
  logic [15:0]      hdr_len;
  logic             bad_len;
  logic [15:0]      word;
  logic             msg_ok;
  kerc_pkg::err_e   final_err;

  assign b          = q_head_i.msg_byte;
  assign can_finish = !out_valid_q || out_ready_i;
  // A final byte waits until the result register is free.
  assign q_pop_o    = !q_empty_i && (!q_head_i.last_byte || can_finish);

  assign hdr_len = {word_high_q, b};
  assign bad_len = (hdr_len < 16'd2) || hdr_len[0];
  assign word    = {word_high_q, b};

  always_comb begin
    phase_d       = phase_q;
    rec_type_d    = rec_type_q;
    rec_crit_d    = rec_crit_q;
    body_left_d   = body_left_q;
    body_off_d    = body_off_q;
    word_high_d   = word_high_q;
    err_d         = err_q;
    saw_proto_d   = saw_proto_q;
    proto_found_d = proto_found_q;
    aead_found_d  = aead_found_q;
    last_eom_d    = last_eom_q;
    len_over_d    = len_over_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_bits_d    = out_bits_q;
    msg_ok        = 1'b0;
    final_err     = kerc_pkg::ErrNone;

    if (q_pop_o) begin
      if (q_head_i.over_limit) begin
        len_over_d = 1'b1;
      end else begin
        case (phase_q)
          kerc_pkg::PhHdr0: begin
            rec_crit_d = b[7];
            rec_type_d = {b[6:0], 8'h00};
            phase_d    = kerc_pkg::PhHdr1;
          end
          kerc_pkg::PhHdr1: begin
            rec_type_d = {rec_type_q[14:8], b};
            phase_d    = kerc_pkg::PhHdr2;
          end
          kerc_pkg::PhHdr2: begin
            word_high_d = b;
            phase_d     = kerc_pkg::PhHdr3;
          end
          kerc_pkg::PhHdr3: begin
            // Header complete: apply the request rules for this record.
            body_left_d = hdr_len;
            last_eom_d  = rec_crit_q && (rec_type_q == kerc_pkg::RecEom) &&
                          (hdr_len == 16'd0);
            if (err_q == kerc_pkg::ErrNone) begin
              case (rec_type_q)
                kerc_pkg::RecNextProto: begin
                  if (!rec_crit_q || bad_len) begin
                    err_d = kerc_pkg::ErrBad;
                  end else begin
                    saw_proto_d = 1'b1;
                  end
                end
                kerc_pkg::RecAead: begin
                  if (bad_len) begin
                    err_d = kerc_pkg::ErrBad;
                  end
                end
                kerc_pkg::RecError, kerc_pkg::RecWarning, kerc_pkg::RecCookie: begin
                  err_d = kerc_pkg::ErrBad;
                end
                kerc_pkg::RecEom: begin
                  err_d = err_q;
                end
                default: begin
                  if (rec_crit_q) begin
                    err_d = kerc_pkg::ErrCritical;
                  end
                end
              endcase
            end
            body_off_d = '0;
            phase_d    = (hdr_len == 16'd0) ? kerc_pkg::PhHdr0 : kerc_pkg::PhBody;
          end
          kerc_pkg::PhBody: begin
            if (body_off_q < ScanLimit) begin
              if (!body_off_q[0]) begin
                word_high_d = b;
              end else if (err_q == kerc_pkg::ErrNone) begin
                if ((rec_type_q == kerc_pkg::RecNextProto) && (word == wanted_proto_q)) begin
                  proto_found_d = 1'b1;
                end
                if ((rec_type_q == kerc_pkg::RecAead) && (word == wanted_aead_q)) begin
                  aead_found_d = 1'b1;
                end
              end
              body_off_d = body_off_q + OffW'(1);
            end
            body_left_d = body_left_q - 16'd1;
            if (body_left_q == 16'd1) begin
              phase_d = kerc_pkg::PhHdr0;
            end
          end
          default: begin
            phase_d = kerc_pkg::PhHdr0;
          end
        endcase
      end

      if (q_head_i.last_byte) begin
        msg_ok    = !len_over_d && (phase_d == kerc_pkg::PhHdr0) && last_eom_d;
        final_err = saw_proto_d ? err_d : kerc_pkg::ErrBad;
        out_valid_d = 1'b1;
        out_bits_d  = msg_ok ? {aead_found_d, proto_found_d, final_err, 1'b1} : 5'b0;
        // Start the next message from a clean state.
        phase_d       = kerc_pkg::PhHdr0;
        rec_type_d    = '0;
        rec_crit_d    = 1'b0;
        body_left_d   = '0;
        body_off_d    = '0;
        word_high_d   = '0;
        err_d         = kerc_pkg::ErrNone;
        saw_proto_d   = 1'b0;
        proto_found_d = 1'b0;
        aead_found_d  = 1'b0;
        last_eom_d    = 1'b0;
        len_over_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_proto_q <= kerc_pkg::WantedProtocolReset;
      wanted_aead_q  <= kerc_pkg::WantedAeadReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == kerc_pkg::CfgIdxProtocol) begin
        wanted_proto_q <= cfg_data_i;
      end
      if (cfg_idx_i == kerc_pkg::CfgIdxAead) begin
        wanted_aead_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= kerc_pkg::PhHdr0;
      rec_type_q    <= '0;
      rec_crit_q    <= 1'b0;
      body_left_q   <= '0;
      body_off_q    <= '0;
      word_high_q   <= '0;
      err_q         <= kerc_pkg::ErrNone;
      saw_proto_q   <= 1'b0;
      proto_found_q <= 1'b0;
      aead_found_q  <= 1'b0;
      last_eom_q    <= 1'b0;
      len_over_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      rec_type_q    <= rec_type_d;
      rec_crit_q    <= rec_crit_d;
      body_left_q   <= body_left_d;
      body_off_q    <= body_off_d;
      word_high_q   <= word_high_d;
      err_q         <= err_d;
      saw_proto_q   <= saw_proto_d;
      proto_found_q <= proto_found_d;
      aead_found_q  <= aead_found_d;
      last_eom_q    <= last_eom_d;
      len_over_q    <= len_over_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bits_q <= out_bits_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {3'b000, out_bits_q};

endmodule

`default_nettype wire

// ----- rtl/key_exchange_request_checker.sv -----
// ----------------------------------------------------------------------------
// key_exchange_request_checker: streaming checker for key-establishment requests
// Parses a request byte stream into records, checks framing and request
// rules, and reports one result item per message.
// ----------------------------------------------------------------------------
// Usage:
//   Request bytes arrive on the s_axis channel, one byte per item, with
//   tlast set on the final byte of a message. For every message exactly one
//   result item leaves on the m_axis channel after its final byte.
//   The cfg port writes the wanted protocol id (index 0) and the wanted AEAD
//   id (index 1); write them only while no message is in flight.
// Timing:
//   One byte is accepted per cycle, back to back, as long as the four-entry
//   queue between the input side and the parser has room. The parser drains
//   one byte per cycle unless a final byte waits for a busy result register,
//   so the sustained rate is one item per cycle while m_axis_tready is high.
//   A final byte is queued when accepted; its result registers when parsed.
// Reset and stall:
//   Reset clears the parser, the queue and the byte count, and sets the id
//   registers to 0 and 15. If the receiver holds m_axis_tready low, the
//   result waits in its register; the parser keeps consuming the bytes of
//   the next message and only stops at that message's final byte, after
//   which the queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module key_exchange_request_checker #(
  parameter int unsigned MAX_MESSAGE_BYTES = kerc_pkg::MaxMessageBytes,
  parameter int unsigned BODY_SCAN_BYTES   = kerc_pkg::BodyScanBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // Request bytes.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  wire logic        s_axis_tlast,   // last_byte
  // Results.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata    // [0] message_ok, [2:1] error_code,
                                           // [3] protocol_offered,
                                           // [4] aead_offered, [7:5] zero
);

  logic               q_full, q_empty, q_push, q_pop;
  kerc_pkg::q_entry_t q_in, q_head;

  // Input side: accept, count and tag bytes against the size limit.
  kerc_front #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .msg_byte_i  (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  // Decoupling queue between the two sides.
  kerc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  // Parser with the configuration registers and the result register.
  kerc_back #(
    .BODY_SCAN_BYTES (BODY_SCAN_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
